// ===== sv/stsg_pkg.sv =====
package stsg_pkg;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam int unsigned TAYLOR_TERMS = 13;

   // Divisors (2n)(2n+1) of the Taylor recurrence, index n.
   localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
   };

   localparam logic [2:0] REG_PHASE_STEP      = 3'd0;
   localparam logic [2:0] REG_SAMPLE_BITS     = 3'd1;
   localparam logic [2:0] REG_CONTAINER_BYTES = 3'd2;
   localparam logic [2:0] REG_BIG_ENDIAN      = 3'd3;
   localparam logic [2:0] REG_UNSIGNED_OUT    = 3'd4;
   localparam logic [2:0] REG_FLOAT_OUT       = 3'd5;

   typedef struct packed {
      logic restart;
      logic period_end;
   } req_type;

   typedef struct packed {
      logic [31:0]        sample_word;
      logic signed [31:0] sample_value;
      logic               last_of_period;
   } rsp_type;

   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Quarter-wave entry k: sin(pi/2 * k / 2^tbits) as Q1.31, evaluated at elaboration.
   function automatic logic [31:0] quarter_sine(input int unsigned k, input int unsigned tbits);
      logic [127:0] wide;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  r;
      wide = {64'd0, HALF_PI_Q62} * {96'd0, k};
      wide = wide >> tbits;
      x = wide[63:0];
      x2 = q62_mul(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = q62_mul(term, x2) / TAYLOR_DIV[n];
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      r = (sum + 64'h40000000) >> 31;
      if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
      return r[31:0];
   endfunction

endpackage

// ===== sv/stsg_rom.sv =====
module stsg_rom import stsg_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [TABLE_BITS:0] addr,
   output logic [31:0]         data
);

   localparam int DEPTH = (1 << TABLE_BITS) + 1;

   typedef logic [31:0] rom_array_type [DEPTH];

   function automatic rom_array_type build_rom();
      rom_array_type t;
      for (int k = 0; k < DEPTH; k++) t[k] = quarter_sine(k, TABLE_BITS);
      return t;
   endfunction

   localparam rom_array_type ROM_DATA = build_rom();

   logic [31:0] data_ff;

   always_ff @(posedge clock) begin
      if (enable) data_ff <= ROM_DATA[addr];
   end

   assign data = data_ff;

endmodule

// ===== sv/stsg_cell.sv =====
module stsg_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) data_ff <= in_data;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/sine_tone_sample_generator.sv =====
// Sine tone generator: one result item per accepted input item, one item per clock when the
// output side keeps up. Each item passes the quarter-wave ROM read, then the scaling multiply
// and leading-one search, then sample formatting into the output register. The whole
// row of stages moves together, so req_ready is high whenever the output register is empty or
// being taken. The phase advances at each accepted item; restart clears it first.
// Configuration must only be written while no item is in flight.
module sine_tone_sample_generator import stsg_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int S1_W = 2;
   localparam int S2_W = 2 + 31 + 5 + 62;
   localparam int OUT_W = $bits(rsp_type);

   logic [31:0] phase_step_ff;
   logic [5:0]  sample_bits_ff;
   logic [2:0]  container_bytes_ff;
   logic        big_endian_ff, unsigned_out_ff, float_out_ff;
   logic [31:0] phase_ff, phase_in;

   logic        advance, accept;
   logic [31:0] ph;
   logic [TABLE_BITS:0] rom_addr;
   logic [TABLE_BITS-1:0] idx;
   logic [31:0] mag_word;

   logic        s1_valid;
   logic [S1_W-1:0] s1_data;
   logic        s1_neg, s1_pe;

   logic [5:0]  width;
   logic [30:0] maxval;
   logic [4:0]  lead;
   logic [61:0] prod;
   logic        s2_valid;
   logic [S2_W-1:0] s2_data;
   logic        s2_neg, s2_pe;
   logic [30:0] s2_mag;
   logic [4:0]  s2_lead;
   logic [61:0] s2_prod;

   logic [31:0] v, res, word, norm;
   logic [2:0]  cont, nbytes;
   logic [1:0]  pos;
   rsp_type     out_in;
   logic [OUT_W-1:0] out_data;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff      <= '0;
         sample_bits_ff     <= 6'd16;
         container_bytes_ff <= 3'd2;
         big_endian_ff      <= 1'b0;
         unsigned_out_ff    <= 1'b0;
         float_out_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PHASE_STEP:      phase_step_ff      <= csr_wdata;
            REG_SAMPLE_BITS:     sample_bits_ff     <= csr_wdata[5:0];
            REG_CONTAINER_BYTES: container_bytes_ff <= csr_wdata[2:0];
            REG_BIG_ENDIAN:      big_endian_ff      <= csr_wdata[0];
            REG_UNSIGNED_OUT:    unsigned_out_ff    <= csr_wdata[0];
            REG_FLOAT_OUT:       float_out_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign ph       = req_data.restart ? 32'd0 : phase_ff;
   assign phase_in = accept ? ph + phase_step_ff : phase_ff;
   assign idx      = ph[29 -: TABLE_BITS];

   // Odd quadrants run the quarter table backward.
   assign rom_addr = ph[30] ? ((TABLE_BITS+1)'(1) << TABLE_BITS) - {1'b0, idx} : {1'b0, idx};

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= '0;
      else phase_ff <= phase_in;
   end

   stsg_rom #(.TABLE_BITS(TABLE_BITS)) u_rom (
      .clock(clock), .enable(advance), .addr(rom_addr), .data(mag_word)
   );

   stsg_cell #(.WIDTH(S1_W)) u_cell1 (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(accept),
      .in_data({ph[31], req_data.period_end}), .out_valid(s1_valid), .out_data(s1_data)
   );
   assign {s1_neg, s1_pe} = s1_data;

   always_comb begin
      if (sample_bits_ff < 6'd8) width = 6'd8;
      else if (sample_bits_ff > 6'd32) width = 6'd32;
      else width = sample_bits_ff;
      maxval = {31{1'b1}} >> (6'd32 - width);
      prod = {31'd0, mag_word[30:0]} * {31'd0, maxval};
      lead = '0;
      for (int b = 0; b < 31; b++) begin
         if (mag_word[b]) lead = 5'(b);
      end
   end

   stsg_cell #(.WIDTH(S2_W)) u_cell2 (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(s1_valid),
      .in_data({s1_neg, s1_pe, mag_word[30:0], lead, prod}),
      .out_valid(s2_valid), .out_data(s2_data)
   );
   assign {s2_neg, s2_pe, s2_mag, s2_lead, s2_prod} = s2_data;

   always_comb begin
      v    = {1'b0, s2_prod[61:31]};
      norm = {1'b0, s2_mag} << (5'd31 - s2_lead);
      if (float_out_ff) begin
         if (s2_mag == '0) res = '0;
         else res = {s2_neg, 8'({3'd0, s2_lead} + 8'd96), norm[30:8]};
         if (unsigned_out_ff) res[31] = ~res[31];
         nbytes = 3'd4;
      end else begin
         res = s2_neg ? 32'd0 - v : v;
         if (unsigned_out_ff) res = res ^ (32'd1 << (width - 6'd1));
         nbytes = width[5:3];
      end
      if (container_bytes_ff < 3'd1) cont = 3'd1;
      else if (container_bytes_ff > 3'd4) cont = 3'd4;
      else cont = container_bytes_ff;
      if (nbytes > cont) nbytes = cont;
      word = '0;
      pos  = '0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < nbytes) begin
            pos = big_endian_ff ? 2'(cont - 3'd1 - 3'(i)) : 2'(i);
            word[pos*8 +: 8] = res[i*8 +: 8];
         end
      end
      out_in.sample_word    = word;
      out_in.sample_value   = res;
      out_in.last_of_period = s2_pe;
   end

   stsg_cell #(.WIDTH(OUT_W)) u_cell_out (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(s2_valid),
      .in_data(out_in), .out_valid(rsp_valid), .out_data(out_data)
   );
   assign rsp_data = out_data;

endmodule

// ===== sv/stsg_checker.sv =====
module stsg_checker import stsg_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A waiting result item holds until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The stage row advances whenever the output register frees up.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with room downstream");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

bind sine_tone_sample_generator stsg_checker u_stsg_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb import stsg_pkg::*; ();

   localparam logic [2:0] REG_UNUSED = 3'd6;
   localparam int TONE_TABLE_BITS = 10;
   localparam int TONE_TABLE_SIZE = 1 << TONE_TABLE_BITS;
   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   sine_tone_sample_generator dut (.*);

   always #1 clock = ~clock;

   // Expected generator state, kept in step with the register writes.
   logic [31:0] tone_step = '0;
   logic [5:0]  tone_bits = 6'd16;
   logic [2:0]  tone_cont = 3'd2;
   logic        tone_big = 1'b0;
   logic        tone_offset = 1'b0;
   logic        tone_float = 1'b0;
   logic [31:0] tone_phase = '0;
   logic [31:0] sine_rom [0:TONE_TABLE_SIZE];

   req_type pending_items[$];
   rsp_type expected_samples[$];
   int      error_count = 0;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;
   int      results_seen = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   function automatic logic [31:0] rom_entry(input int unsigned k);
      logic [127:0] wide;
      logic [63:0]  x, x2, term, acc, r;
      wide = 128'h6487ED5110B4611A * k;
      x = wide[TONE_TABLE_BITS +: 64];
      wide = x * x;
      x2 = wide[125:62];
      term = x;
      acc = x;
      for (int n = 1; n <= 13; n++) begin
         wide = term * x2;
         term = wide[125:62] / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      r = (acc + 64'h40000000) >> 31;
      if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
      return r[31:0];
   endfunction

   function automatic rsp_type next_sample(input req_type item);
      rsp_type     s;
      logic [31:0] mag, res, v, mant;
      logic [63:0] prod;
      logic        neg;
      int          width, cont, nbytes, lead, pos;
      if (item.restart) tone_phase = '0;
      mag = tone_phase[30] ? sine_rom[TONE_TABLE_SIZE - tone_phase[29:20]]
                           : sine_rom[tone_phase[29:20]];
      neg = tone_phase[31];
      width = tone_bits < 8 ? 8 : (tone_bits > 32 ? 32 : tone_bits);
      if (tone_float) begin
         width = 32;
         if (mag == 0) res = '0;
         else begin
            lead = 0;
            for (int b = 0; b < 32; b++) if (mag[b]) lead = b;
            if (lead >= 23) mant = (mag >> (lead - 23)) & 32'h7FFFFF;
            else mant = (mag << (23 - lead)) & 32'h7FFFFF;
            res = {neg, 8'(lead + 96), mant[22:0]};
         end
      end else begin
         prod = mag * ((64'd1 << (width - 1)) - 1);
         v = prod[62:31];
         res = neg ? -v : v;
      end
      if (tone_offset) res[width - 1] = ~res[width - 1];
      cont = tone_cont < 1 ? 1 : (tone_cont > 4 ? 4 : tone_cont);
      nbytes = width / 8;
      if (nbytes > cont) nbytes = cont;
      s.sample_word = '0;
      for (int i = 0; i < nbytes; i++) begin
         pos = tone_big ? cont - 1 - i : i;
         s.sample_word[8 * pos +: 8] = res[8 * i +: 8];
      end
      s.sample_value = res;
      s.last_of_period = item.period_end;
      tone_phase = tone_phase + tone_step;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_samples.push_back(next_sample(req_data));
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor; after a while it holds off for a long stretch to fill the block.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected item", rsp_data.sample_word, '0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample_word !== want.sample_word)
                  report_mismatch("sample_word", rsp_data.sample_word, want.sample_word);
               if (rsp_data.sample_value !== want.sample_value)
                  report_mismatch("sample_value", rsp_data.sample_value, want.sample_value);
               if (rsp_data.last_of_period !== want.last_of_period)
                  report_mismatch("last_of_period", rsp_data.last_of_period,
                                  want.last_of_period);
            end
            results_seen++;
            if (results_seen == 150) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= receiver_idle_pct;
         end
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_tone(input logic [31:0] step, input logic [31:0] bits,
                           input logic [31:0] cont, input logic big, input logic offset,
                           input logic flt);
      logic [31:0] vals [0:5];
      vals = '{step, bits, cont, {31'd0, big}, {31'd0, offset}, {31'd0, flt}};
      wait_idle();
      for (int i = 0; i <= 6; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         // The last write goes to an index with no register and must change nothing.
         csr_index <= (i == 6) ? REG_UNUSED : 3'(i);
         csr_wdata <= (i == 6) ? $urandom : vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      tone_step = step;
      tone_bits = bits[5:0];
      tone_cont = cont[2:0];
      tone_big = big;
      tone_offset = offset;
      tone_float = flt;
   endtask

   task automatic queue_items(input int count, input int restart_pct);
      req_type item;
      for (int i = 0; i < count; i++) begin
         item.restart = $urandom_range(99) < restart_pct;
         item.period_end = $urandom_range(1);
         pending_items.push_back(item);
      end
   endtask

   initial begin
      int widths [0:3];
      widths = '{8, 16, 24, 32};
      for (int k = 0; k <= TONE_TABLE_SIZE; k++) sine_rom[k] = rom_entry(k);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, restart marks, quadrant walks in integer and float.
      pending_items.push_back('{restart: 1'b1, period_end: 1'b0});
      pending_items.push_back('{restart: 1'b0, period_end: 1'b1});
      pending_items.push_back('{restart: 1'b1, period_end: 1'b1});
      set_tone(32'h2000_0000, 32, 4, 1'b0, 1'b0, 1'b0);
      queue_items(5, 0);
      set_tone(32'h2000_0000, 8, 0, 1'b1, 1'b1, 1'b1);
      queue_items(5, 0);
      set_tone(32'hFFFF_FFFF, 63, 7, 1'b1, 1'b1, 1'b0);
      queue_items(3, 0);
      set_tone(32'h0010_0000, 0, 1, 1'b0, 1'b1, 1'b0);
      queue_items(3, 0);
      set_tone(32'h0123_4567, 12, 3, 1'b1, 1'b0, 1'b0);
      queue_items(3, 0);
      set_tone(32'h0, 24, 2, 1'b1, 1'b0, 1'b0);
      queue_items(2, 50);

      // Random phases: receiver-heavy idling, sender-heavy idling, then none.
      for (int p = 0; p < 12; p++) begin
         sender_idle_pct = p < 4 ? 36 : (p < 8 ? 85 : 0);
         receiver_idle_pct = p < 4 ? 85 : (p < 8 ? 36 : 0);
         set_tone(($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000),
                  ($urandom_range(7) == 0) ? $urandom_range(63) : widths[$urandom_range(3)],
                  ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1),
                  $urandom_range(1), $urandom_range(1), $urandom_range(2) == 0);
         queue_items(58, 6);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
